// ===== design/ctks_pkg.sv =====
// ----------------------------------------------------------------------------
// ctks_pkg
// Shared types, constants and the symbol key table of the crank selector.
// ----------------------------------------------------------------------------
package ctks_pkg;

	localparam int DATA_W    = 16;
	localparam int REM_W     = 17;
	localparam int IDX_W     = 5;
	localparam int KEY_W     = 8;
	localparam int CFG_IDX_W = 1;
	localparam int DIV_CNT_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_STEP_DIVISOR      = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REVERSE_THRESHOLD = 1'd1;

	localparam logic [DATA_W-1:0] STEP_DIVISOR_RESET      = 16'd1000;
	localparam logic [DATA_W-1:0] REVERSE_THRESHOLD_RESET = 16'd5;

	localparam logic [KEY_W-1:0]     BKSP_CODE     = 8'd14;
	localparam logic [REM_W-1:0]     REM_MAX       = 17'h1FFFF;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = 5'(REM_W - 1);

	typedef enum logic [1:0] {
		KIND_FIRST,
		KIND_BACKSPACE,
		KIND_SYMBOL
	} key_kind_t;

	typedef struct packed {
		logic      load;
		logic      apply;
		logic      div_step;
		logic      commit;
		logic      emit;
		key_kind_t kind;
		logic      last;
	} ctks_cmd_t;

	typedef struct packed {
		logic flip;
		logic ignore;
		logic qnz;
	} ctks_status_t;

	function automatic logic [KEY_W-1:0] sym_key(input logic [IDX_W-1:0] idx);
		logic [KEY_W-1:0] k;
		case (idx)
			5'd0:  k = 8'd30;
			5'd1:  k = 8'd48;
			5'd2:  k = 8'd46;
			5'd3:  k = 8'd32;
			5'd4:  k = 8'd18;
			5'd5:  k = 8'd33;
			5'd6:  k = 8'd34;
			5'd7:  k = 8'd35;
			5'd8:  k = 8'd23;
			5'd9:  k = 8'd36;
			5'd10: k = 8'd37;
			5'd11: k = 8'd38;
			5'd12: k = 8'd50;
			5'd13: k = 8'd49;
			5'd14: k = 8'd24;
			5'd15: k = 8'd25;
			5'd16: k = 8'd16;
			5'd17: k = 8'd19;
			5'd18: k = 8'd31;
			5'd19: k = 8'd20;
			5'd20: k = 8'd22;
			5'd21: k = 8'd47;
			5'd22: k = 8'd17;
			5'd23: k = 8'd45;
			5'd24: k = 8'd21;
			5'd25: k = 8'd44;
			5'd26: k = 8'd57;
			5'd27: k = 8'd28;
			default: k = 8'd0;
		endcase
		return k;
	endfunction

endpackage

// ===== design/ctks_if.sv =====
// ----------------------------------------------------------------------------
// ctks_if
// Valid/ready channels for crank deltas and for key tap items.
// ----------------------------------------------------------------------------
interface ctks_in_if;
	logic                valid;
	logic                ready;
	logic signed [15:0]  delta;

	modport source (output valid, output delta, input ready);
	modport sink (input valid, input delta, output ready);
endinterface

interface ctks_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  key_code;
	logic [4:0]  symbol_index;
	logic        last;

	modport source (output valid, output key_code, output symbol_index, output last,
		input ready);
	modport sink (input valid, input key_code, input symbol_index, input last,
		output ready);
endinterface

// ===== design/ctks_dp.sv =====
// ----------------------------------------------------------------------------
// ctks_dp
// Datapath: configuration, direction, remainder, symbol index, a bit-serial
// restoring divider and the output item register.
// ----------------------------------------------------------------------------
module ctks_dp #(
	parameter int NUM_SYMBOLS = 28
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [ctks_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [ctks_pkg::DATA_W-1:0]             cfg_data,
	input  logic signed [ctks_pkg::DATA_W-1:0]      delta,
	input  ctks_pkg::ctks_cmd_t                     cmd,
	output ctks_pkg::ctks_status_t                  status,
	output logic [ctks_pkg::KEY_W-1:0]              key_code,
	output logic [ctks_pkg::IDX_W-1:0]              symbol_index,
	output logic                                    last
);
	import ctks_pkg::*;

	localparam logic [IDX_W:0] NSYM = (IDX_W+1)'(NUM_SYMBOLS);

	logic [DATA_W-1:0] divisor_q;
	logic [DATA_W-1:0] threshold_q;
	logic              dir_neg_q;
	logic [REM_W-1:0]  rem_q;
	logic [IDX_W-1:0]  sel_q;
	logic              neg_q;
	logic [DATA_W-1:0] mag_q;
	logic [REM_W-1:0]  num_q;
	logic [DATA_W-1:0] part_q;
	logic [IDX_W-1:0]  qmod_q;
	logic              qnz_q;
	logic [KEY_W-1:0]  key_q;
	logic [IDX_W-1:0]  idx_q;
	logic              last_q;

	logic              flip;
	logic [REM_W:0]    sum;
	logic [REM_W-1:0]  dividend;
	logic [DATA_W-1:0] div_eff;
	logic [REM_W-1:0]  trial;
	logic              qbit;
	logic [REM_W-1:0]  trial_sub;
	logic [IDX_W:0]    qmod_dbl;
	logic [IDX_W:0]    sel_sum;
	logic [IDX_W-1:0]  sel_next;
	logic [KEY_W-1:0]  emit_key;

	always_comb begin
		flip      = neg_q != dir_neg_q;
		sum       = {1'b0, rem_q} + {2'b00, mag_q};
		dividend  = sum[REM_W] ? REM_MAX : sum[REM_W-1:0];
		div_eff   = (divisor_q == '0) ? DATA_W'(1) : divisor_q;
		trial     = {part_q, num_q[REM_W-1]};
		qbit      = trial >= {1'b0, div_eff};
		trial_sub = trial - {1'b0, div_eff};
		qmod_dbl  = {qmod_q, qbit};
		if (qmod_dbl >= NSYM) begin
			qmod_dbl = qmod_dbl - NSYM;
		end
		sel_sum = {1'b0, sel_q} + {1'b0, qmod_q};
		if (sel_sum >= NSYM) begin
			sel_sum = sel_sum - NSYM;
		end
		sel_next = sel_sum[IDX_W-1:0];
		case (cmd.kind)
			KIND_FIRST:     emit_key = sym_key('0);
			KIND_BACKSPACE: emit_key = BKSP_CODE;
			KIND_SYMBOL:    emit_key = sym_key(sel_q);
			default:        emit_key = '0;
		endcase
	end

	assign status.flip   = flip;
	assign status.ignore = flip && (mag_q < threshold_q);
	assign status.qnz    = qnz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			divisor_q   <= STEP_DIVISOR_RESET;
			threshold_q <= REVERSE_THRESHOLD_RESET;
			dir_neg_q   <= 1'b0;
			rem_q       <= '0;
			sel_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_STEP_DIVISOR:      divisor_q   <= cfg_data;
					REG_REVERSE_THRESHOLD: threshold_q <= cfg_data;
					default:               ;
				endcase
			end
			if (cmd.apply && flip) begin
				dir_neg_q <= neg_q;
				sel_q     <= '0;
			end
			if (cmd.commit) begin
				rem_q <= {1'b0, part_q};
				sel_q <= sel_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			neg_q <= delta[DATA_W-1];
			mag_q <= delta[DATA_W-1] ? (~delta + 1'b1) : delta;
		end
		if (cmd.apply) begin
			num_q  <= dividend;
			part_q <= '0;
			qmod_q <= '0;
			qnz_q  <= 1'b0;
		end
		if (cmd.div_step) begin
			num_q  <= {num_q[REM_W-2:0], 1'b0};
			part_q <= qbit ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
			qmod_q <= qmod_dbl[IDX_W-1:0];
			qnz_q  <= qnz_q | qbit;
		end
		if (cmd.emit) begin
			key_q  <= emit_key;
			idx_q  <= sel_q;
			last_q <= cmd.last;
		end
	end

	assign key_code     = key_q;
	assign symbol_index = idx_q;
	assign last         = last_q;

endmodule

// ===== design/ctks_ctrl.sv =====
// ----------------------------------------------------------------------------
// ctks_ctrl
// Controller: takes one item, runs the divider and hands out up to three taps.
// ----------------------------------------------------------------------------
module ctks_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	output logic                   out_valid,
	input  logic                   out_ready,
	output ctks_pkg::ctks_cmd_t    cmd,
	input  ctks_pkg::ctks_status_t status
);
	import ctks_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_DIV,
		ST_COMMIT,
		ST_PICK,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  pend_first_q;
	logic                  pend_bs_q;
	logic                  pend_sym_q;
	logic                  out_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.kind     = KIND_FIRST;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.apply    = (state_q == ST_EVAL) && !status.ignore;
		cmd.div_step = state_q == ST_DIV;
		cmd.commit   = state_q == ST_COMMIT;
		if (state_q == ST_PICK) begin
			if (pend_first_q) begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_FIRST;
				cmd.last = !pend_bs_q;
			end else if (pend_bs_q) begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_BACKSPACE;
			end else if (pend_sym_q) begin
				cmd.emit = 1'b1;
				cmd.kind = KIND_SYMBOL;
				cmd.last = 1'b1;
			end
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			pend_first_q <= 1'b0;
			pend_bs_q    <= 1'b0;
			pend_sym_q   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (status.ignore) begin
						state_q <= ST_IDLE;
					end else begin
						pend_first_q <= status.flip;
						cnt_q        <= '0;
						state_q      <= ST_DIV;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == DIV_LAST_STEP) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					pend_bs_q  <= status.qnz;
					pend_sym_q <= status.qnz;
					state_q    <= ST_PICK;
				end
				ST_PICK: begin
					if (cmd.emit) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_EMIT;
						case (cmd.kind)
							KIND_FIRST:     pend_first_q <= 1'b0;
							KIND_BACKSPACE: pend_bs_q    <= 1'b0;
							default:        pend_sym_q   <= 1'b0;
						endcase
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						out_valid_q <= 1'b0;
						state_q     <= ST_PICK;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/crank_to_keystroke_selector_unit.sv =====
// ----------------------------------------------------------------------------
// crank_to_keystroke_selector_unit
// Turns signed crank deltas into key tap items that cycle through symbols.
// ----------------------------------------------------------------------------
// The block takes one delta item at a time. An ignored delta frees the input
// without a division; any other delta runs a bit-serial division of the
// movement remainder and then sends up to three tap items. The next delta is
// taken only after the last tap item, if any, has been accepted. Configuration
// registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while no item is in flight, as the block does not enforce it.
module crank_to_keystroke_selector_unit #(
	parameter int NUM_SYMBOLS = 28
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ctks_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ctks_pkg::DATA_W-1:0]    cfg_data,
	ctks_in_if.sink                        in_ch,
	ctks_out_if.source                     out_ch
);
	import ctks_pkg::*;

	ctks_cmd_t    cmd;
	ctks_status_t status;

	ctks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd),
		.status    (status)
	);

	ctks_dp #(
		.NUM_SYMBOLS (NUM_SYMBOLS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.delta        (in_ch.delta),
		.cmd          (cmd),
		.status       (status),
		.key_code     (out_ch.key_code),
		.symbol_index (out_ch.symbol_index),
		.last         (out_ch.last)
	);

endmodule

// ===== design/ctks_checker.sv =====
// ----------------------------------------------------------------------------
// ctks_checker
// Port-level checks of the crank selector, bound to the top level.
// ----------------------------------------------------------------------------
module ctks_checker #(
	parameter int NUM_SYMBOLS = 28
) (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] key_code,
	input logic [4:0] symbol_index,
	input logic       last
);
	import ctks_pkg::*;

	// The block never takes a new item while a tap is still offered.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a tap item is offered");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (6'(symbol_index) < 6'(NUM_SYMBOLS)))
		else $error("symbol index out of range");

	// A backspace is always followed by the new symbol's key.
	a_bs_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && key_code == BKSP_CODE) |-> !last)
		else $error("backspace marked as final tap");

	a_more_after_nonlast: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !last) |=> !in_ready)
		else $error("input taken before all taps of an item were sent");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(key_code) && $stable(last)))
		else $error("stalled tap item changed");

endmodule

bind crank_to_keystroke_selector_unit ctks_checker #(
	.NUM_SYMBOLS (NUM_SYMBOLS)
) u_ctks_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.key_code     (out_ch.key_code),
	.symbol_index (out_ch.symbol_index),
	.last         (out_ch.last)
);

// ===== dv/tb_crank_to_keystroke_selector_unit.sv =====
// ----------------------------------------------------------------------------
// tb_crank_to_keystroke_selector_unit
// Self-checking bench for the crank selector. Directed and random crank deltas
// are sent under several register settings, with bursty input and a stalling
// output. Expected key taps are computed at input acceptance and compared with
// each accepted tap item in order.
// ----------------------------------------------------------------------------
module tb_crank_to_keystroke_selector_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import ctks_pkg::*;

	localparam int N_SYMBOLS   = 28;
	localparam int REM_CEIL    = 131071;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 60;
	localparam int RANDOM_PER_PHASE = 90;

	typedef struct {
		logic [7:0] key_code;
		logic [4:0] symbol_index;
		logic       last;
	} tap_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [DATA_W-1:0] cfg_data;

	ctks_in_if in_ch();
	ctks_out_if out_ch();

	crank_to_keystroke_selector_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [7:0] symbol_key [0:31];

	logic signed [15:0] delta_q [$];
	tap_t taps_due [$];

	int unsigned step_div;
	int unsigned rev_thresh;
	logic dir_negative;
	int unsigned move_rem;
	int unsigned cur_symbol;

	logic run_negative;
	int errors;
	int cycles;
	logic in_acc;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic predict_taps(input logic signed [15:0] d);
		logic neg;
		int unsigned mag;
		int unsigned sum;
		int unsigned dv;
		int unsigned inc;
		logic [7:0] keys [$];
		tap_t t;
		neg = d[15];
		mag = neg ? int'(-int'(d)) : int'(d);
		if (neg != dir_negative) begin
			if (mag < rev_thresh)
				return;
			dir_negative = neg;
			cur_symbol = 0;
			keys.push_back(symbol_key[0]);
		end
		sum = move_rem + mag;
		if (sum > REM_CEIL)
			sum = REM_CEIL;
		dv = (step_div == 0) ? 1 : step_div;
		inc = sum / dv;
		move_rem = sum;
		if (inc > 0) begin
			move_rem = sum % dv;
			cur_symbol = (cur_symbol + inc) % N_SYMBOLS;
			keys.push_back(BKSP_CODE);
			keys.push_back(symbol_key[cur_symbol]);
		end
		foreach (keys[k]) begin
			t.key_code = keys[k];
			t.symbol_index = 5'(cur_symbol);
			t.last = (k == keys.size() - 1);
			taps_due.push_back(t);
		end
	endtask

	function automatic logic signed [15:0] random_delta();
		int m;
		int span;
		int pick;
		pick = $urandom_range(0, 99);
		span = (step_div == 0) ? 2 : 2 * step_div;
		if (span > 32767)
			span = 32767;
		if (pick < 55) begin
			m = $urandom_range(0, span);
			return run_negative ? 16'(-m) : 16'(m);
		end
		if (pick < 70) begin
			m = int'(rev_thresh) + int'($urandom_range(0, 2)) - 1;
			run_negative = !run_negative;
			if (m < 0)
				m = 0;
			if (m > 32768)
				m = 32768;
			if (!run_negative && m > 32767)
				m = 32767;
			return run_negative ? 16'(-m) : 16'(m);
		end
		if (pick < 85)
			return 16'($urandom);
		m = $urandom_range(0, 10);
		return $urandom_range(0, 1) ? 16'(-m) : 16'(m);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_STEP_DIVISOR)
			step_div = val;
		else
			rev_thresh = val;
	endtask

	task automatic settle();
		while (delta_q.size() != 0 || in_ch.valid || taps_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic random_phase(input int count);
		repeat (count) delta_q.push_back(random_delta());
		settle();
	endtask

	// Sender: bursts of items separated by random gaps, changed at the falling edge.
	int gap_left;
	int burst_left;
	always @(negedge clk) begin
		if (!in_ch.valid || in_acc) begin
			if (gap_left > 0) begin
				in_ch.valid <= 1'b0;
				gap_left--;
			end else if (delta_q.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.delta <= delta_q.pop_front();
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
				end
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: ready follows a random mode that is changed at random times.
	int rdy_mode;
	int rdy_left;
	int rdy_phase;
	always @(negedge clk) begin
		logic r;
		if (rdy_left == 0) begin
			rdy_mode = $urandom_range(0, 3);
			rdy_left = $urandom_range(5, 60);
		end
		rdy_left--;
		rdy_phase++;
		case (rdy_mode)
			0: r = 1'b1;
			1: r = $urandom_range(0, 1);
			2: r = 1'b0;
			default: r = (rdy_phase % 4 == 0);
		endcase
		out_ch.ready <= r;
	end

	always @(posedge clk) begin : monitor
		tap_t want;
		in_acc <= in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (taps_due.size() == 0) begin
					$display("%0t: unexpected tap item key_code=%0d symbol_index=%0d last=%0b",
						$time, out_ch.key_code, out_ch.symbol_index, out_ch.last);
					errors++;
				end else begin
					want = taps_due.pop_front();
					if (out_ch.key_code !== want.key_code) begin
						$display("%0t: key_code expected %0d actual %0d",
							$time, want.key_code, out_ch.key_code);
						errors++;
					end
					if (out_ch.symbol_index !== want.symbol_index) begin
						$display("%0t: symbol_index expected %0d actual %0d",
							$time, want.symbol_index, out_ch.symbol_index);
						errors++;
					end
					if (out_ch.last !== want.last) begin
						$display("%0t: last expected %0b actual %0b",
							$time, want.last, out_ch.last);
						errors++;
					end
				end
			end
			if (in_ch.valid && in_ch.ready)
				predict_taps(in_ch.delta);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_crank_to_keystroke_selector_unit: errors");
			$finish;
		end
	end

	initial begin
		symbol_key = '{30, 48, 46, 32, 18, 33, 34, 35, 23, 36, 37, 38, 50, 49,
			24, 25, 16, 19, 31, 20, 22, 47, 17, 45, 21, 44, 57, 28, 0, 0, 0, 0};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.delta = '0;
		out_ch.ready = 1'b0;
		step_div = STEP_DIVISOR_RESET;
		rev_thresh = REVERSE_THRESHOLD_RESET;
		dir_negative = 1'b0;
		move_rem = 0;
		cur_symbol = 0;
		run_negative = 1'b0;
		errors = 0;
		cycles = 0;
		gap_left = 0;
		burst_left = 0;
		rdy_mode = 0;
		rdy_left = 0;
		rdy_phase = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset settings: zero delta, one step, ignored and exact reversals,
		// multi-step jumps at both extremes of the delta.
		delta_q = '{16'sd0, 16'sd999, 16'sd1, -16'sd4, -16'sd5, 16'sd32767,
			-16'sh8000, -16'sd1, 16'sd2500, 16'sd4};
		settle();

		// Divisor 1 and threshold 0: every nonzero delta steps, a zero delta flips to positive.
		write_reg(REG_STEP_DIVISOR, 16'd1);
		write_reg(REG_REVERSE_THRESHOLD, 16'd0);
		delta_q = '{-16'sd1, 16'sd0, -16'sh8000, 16'sd32767, 16'sd27, 16'sd28};
		settle();

		// Divisor 0 acts as 1; only the most negative delta can reverse.
		write_reg(REG_STEP_DIVISOR, 16'd0);
		write_reg(REG_REVERSE_THRESHOLD, 16'd32768);
		delta_q = '{-16'sd32767, -16'sh8000, 16'sd32767, 16'sd0, -16'sd3};
		settle();

		// Largest values: reversal impossible, steps need several deltas.
		write_reg(REG_STEP_DIVISOR, 16'hFFFF);
		write_reg(REG_REVERSE_THRESHOLD, 16'hFFFF);
		delta_q = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767};
		settle();

		random_phase(RANDOM_PER_PHASE);
		write_reg(REG_STEP_DIVISOR, STEP_DIVISOR_RESET);
		write_reg(REG_REVERSE_THRESHOLD, REVERSE_THRESHOLD_RESET);
		random_phase(RANDOM_PER_PHASE);
		write_reg(REG_STEP_DIVISOR, 16'($urandom_range(1, 64)));
		write_reg(REG_REVERSE_THRESHOLD, 16'($urandom_range(0, 50)));
		random_phase(RANDOM_PER_PHASE);
		write_reg(REG_STEP_DIVISOR, 16'($urandom_range(100, 3000)));
		write_reg(REG_REVERSE_THRESHOLD, 16'd0);
		random_phase(RANDOM_PER_PHASE);
		write_reg(REG_STEP_DIVISOR, 16'($urandom));
		write_reg(REG_REVERSE_THRESHOLD, 16'($urandom));
		random_phase(RANDOM_PER_PHASE);

		if (errors == 0)
			$display("tb_crank_to_keystroke_selector_unit: clean");
		else
			$display("tb_crank_to_keystroke_selector_unit: errors");
		$finish;
	end

endmodule

// ===== sim.f =====
design/ctks_pkg.sv
design/ctks_if.sv
design/ctks_dp.sv
design/ctks_ctrl.sv
design/crank_to_keystroke_selector_unit.sv
design/ctks_checker.sv
dv/tb_crank_to_keystroke_selector_unit.sv
